// ----- hdl/cbba_pkg.sv -----
// ----------------------------------------------------------------------------
// cbba_pkg
// Shared types and constants for the contiguous block bitmap allocator.
// ----------------------------------------------------------------------------
package cbba_pkg;

  // default number of blocks held in the bitmap
  localparam int MAP_BLOCKS_DEF = 1024;

  // bitmap word: blocks handled per cycle by the word unit
  localparam int WORD_BITS = 16;
  localparam int OFF_W     = 4;             // bit offset inside a word
  localparam int POS_W     = 12;            // block position / length, up to 2047
  localparam int ROW_W     = POS_W - OFF_W; // word row of a block position

  // disk size register
  localparam int               DISK_W          = 11;
  localparam logic [DISK_W-1:0] DISK_BLOCKS_RST = 11'd1024;

  // commands
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_RESERVE = 2'd2;
  localparam logic [1:0] CMD_TEST    = 2'd3;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // free-run search over one word
  typedef struct packed {
    logic [ROW_W-1:0] row;      // row of the word being scanned
    logic [ROW_W-1:0] lim_row;  // row of the last block on the disk
    logic [OFF_W-1:0] lim_off;  // offset of the last block on the disk
    logic [POS_W-1:0] count;    // requested run length
    logic [POS_W-1:0] run_len;  // free run carried in from the lower word
  } scan_req_t;

  typedef struct packed {
    logic             found;    // a run long enough ends in this word
    logic [POS_W-1:0] first;    // first block of that run
    logic [POS_W-1:0] run_len;  // free run carried out of this word
  } scan_res_t;

  // range update of one word
  typedef struct packed {
    logic [ROW_W-1:0] row;      // row of the word being updated
    logic [ROW_W-1:0] lo_row;   // first block of the range
    logic [OFF_W-1:0] lo_off;
    logic [ROW_W-1:0] hi_row;   // last block of the range
    logic [OFF_W-1:0] hi_off;
    logic             set;      // value written into the range
  } mark_req_t;

endpackage

// ----- hdl/contiguous_block_bitmap_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// contiguous_block_bitmap_allocator_unit
// First-fit contiguous block allocator over a one-bit-per-block bitmap.
// ----------------------------------------------------------------------------
// Takes one command word at a time and returns one result word for it. The
// bitmap sits in a RAM of 16-bit words and every command walks it one word
// per cycle through the shared word unit, so the cost follows the rows
// touched: allocate scans R words, where R is the number of words scanned
// up to the row where the run completes (at most ceil(disk_blocks/16), 64
// for a 1024-block disk), then updates the M words the run spans; free and
// reserve update M words; test reads one word; a range or size error is
// answered straight from the range check. in_ready is low for the whole
// command. After reset a clearing pass writes the bitmap to all-free, one
// word per cycle, before the first command is taken; disk size writes are
// accepted throughout.
// ----------------------------------------------------------------------------
module contiguous_block_bitmap_allocator_unit
  import cbba_pkg::*;
#(
  parameter int MAP_BLOCKS = MAP_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // disk size register
  input  logic              cfg_we,
  input  logic [DISK_W-1:0] cfg_wdata,
  // command channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic [9:0]        start_block,
  input  logic [10:0]       block_count,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [9:0]        alloc_start,
  output logic              allocated
);

  localparam int ROWS     = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SIZE_CAP = (MAP_BLOCKS < 2047) ? MAP_BLOCKS : 2047;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_MARK0 = 3'd5;
  localparam logic [2:0] S_MARK  = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0]        state;
  logic [ADDR_W-1:0] clr_row;
  logic [DISK_W-1:0] disk_blocks;

  // captured command
  logic [1:0]  cmd_q;
  logic [9:0]  start_q;
  logic [10:0] count_q;

  // scan and mark context
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] scan_row;
  logic [POS_W-1:0] run_len;
  logic [POS_W-1:0] lo;
  logic [POS_W-1:0] last;
  logic [ROW_W-1:0] mark_row;
  logic             set_bit;

  // pending result
  logic [1:0] res_status;
  logic [9:0] res_run;
  logic       res_bit;

  // derived values
  logic [POS_W-1:0] disk_size;
  logic [POS_W-1:0] size_m1;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] end_pos;
  logic [ROW_W-1:0] lim_row;
  logic [ROW_W-1:0] last_row;

  // RAM and word unit wiring
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  scan_req_t            scan_req;
  scan_res_t            scan_res;
  mark_req_t            mark_req;
  logic [WORD_BITS-1:0] mark_word;

  // effective disk size and range bounds
  always_comb begin
    disk_size = ({1'b0, disk_blocks} > POS_W'(SIZE_CAP)) ? POS_W'(SIZE_CAP)
                                                         : {1'b0, disk_blocks};
    size_m1   = disk_size - POS_W'(1);
    lim_row   = size_m1[POS_W-1:OFF_W];
    start_pos = POS_W'(start_q);
    end_pos   = start_pos + POS_W'(count_q);
    last_row  = last[POS_W-1:OFF_W];
  end

  assign in_ready = (state == S_IDLE);

  // word unit requests
  always_comb begin
    scan_req.row     = scan_row;
    scan_req.lim_row = lim_row;
    scan_req.lim_off = size_m1[OFF_W-1:0];
    scan_req.count   = POS_W'(count_q);
    scan_req.run_len = run_len;
    mark_req.row     = mark_row;
    mark_req.lo_row  = lo[POS_W-1:OFF_W];
    mark_req.lo_off  = lo[OFF_W-1:0];
    mark_req.hi_row  = last_row;
    mark_req.hi_off  = last[OFF_W-1:0];
    mark_req.set     = set_bit;
  end

  cbba_word_unit u_word (
    .word      (rd_data),
    .scan_req  (scan_req),
    .scan_res  (scan_res),
    .mark_req  (mark_req),
    .mark_word (mark_word)
  );

  // RAM port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_row;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_CHECK: begin
        rd_en   = 1'b1;
        rd_addr = (cmd_q == CMD_ALLOC) ? '0 : ADDR_W'(start_pos[POS_W-1:OFF_W]);
      end
      S_SCAN: begin
        rd_en   = (scan_row != lim_row);
        rd_addr = ADDR_W'(rd_row);
      end
      S_MARK0: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(lo[POS_W-1:OFF_W]);
      end
      S_MARK: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(mark_row);
        wr_data = mark_word;
        rd_en   = (mark_row != last_row);
        rd_addr = ADDR_W'(mark_row + ROW_W'(1));
      end
      default: begin
      end
    endcase
  end

  cbba_map_ram #(
    .MAP_BLOCKS (MAP_BLOCKS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // disk size register
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_blocks <= DISK_BLOCKS_RST;
    end else if (cfg_we) begin
      disk_blocks <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_row <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + ADDR_W'(1);
          if (clr_row == ADDR_W'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_q   <= command;
            start_q <= start_block;
            count_q <= block_count;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_status <= ST_OK;
          res_run    <= '0;
          res_bit    <= 1'b0;
          unique case (cmd_q) inside
            CMD_ALLOC: begin
              rd_row   <= ROW_W'(1);
              scan_row <= '0;
              run_len  <= '0;
              set_bit  <= 1'b1;
              if (disk_size == '0) begin
                res_status <= ST_NOSPACE;
                state      <= S_RESP;
              end else begin
                state <= S_SCAN;
              end
            end
            CMD_FREE, CMD_RESERVE: begin
              lo      <= start_pos;
              last    <= end_pos - POS_W'(1);
              set_bit <= (cmd_q == CMD_RESERVE);
              if (end_pos > disk_size) begin
                res_status <= ST_RANGE;
                state      <= S_RESP;
              end else if (count_q == '0) begin
                state <= S_RESP;
              end else begin
                state <= S_MARK0;
              end
            end
            CMD_TEST: begin
              if (start_pos >= disk_size) begin
                res_status <= ST_RANGE;
                state      <= S_RESP;
              end else begin
                state <= S_TEST;
              end
            end
            default: begin
              state <= S_RESP;
            end
          endcase
        end
        S_SCAN: begin
          rd_row   <= rd_row + ROW_W'(1);
          scan_row <= scan_row + ROW_W'(1);
          run_len  <= scan_res.run_len;
          if (scan_res.found) begin
            res_run <= scan_res.first[9:0];
            lo      <= scan_res.first;
            last    <= scan_res.first + POS_W'(count_q) - POS_W'(1);
            state   <= (count_q == '0) ? S_RESP : S_MARK0;
          end else if (scan_row == lim_row) begin
            res_status <= ST_NOSPACE;
            state      <= S_RESP;
          end
        end
        S_TEST: begin
          res_bit <= rd_data[start_q[OFF_W-1:0]];
          state   <= S_RESP;
        end
        S_MARK0: begin
          mark_row <= lo[POS_W-1:OFF_W];
          state    <= S_MARK;
        end
        S_MARK: begin
          mark_row <= mark_row + ROW_W'(1);
          if (mark_row == last_row) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && (!out_valid || out_ready)) begin
      status      <= res_status;
      alloc_start <= res_run;
      allocated   <= res_bit;
    end
  end

`ifndef SYNTHESIS
  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_NOSPACE || status == ST_RANGE))
    else $error("undefined status code on result");

  // failed commands carry no run start and no tested bit
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> alloc_start == '0 && allocated == 1'b0)
    else $error("failed command returned payload");

  // bitmap written only by the clearing pass and range updates
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CLEAR || state == S_MARK))
    else $error("bitmap write outside clear or mark");

  // scan never runs past the last row of the disk
  a_scan_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_row <= lim_row)
    else $error("scan past disk end");

  // every accepted command starts with the range check
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_CHECK && !in_ready)
    else $error("command accepted without range check");
`endif

endmodule

// ----- hdl/cbba_map_ram.sv -----
// ----------------------------------------------------------------------------
// cbba_map_ram
// Allocation bitmap, one bit per block, stored as 16-bit words.
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module cbba_map_ram
  import cbba_pkg::*;
#(
  parameter int MAP_BLOCKS = MAP_BLOCKS_DEF,
  localparam int ROWS   = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS,
  localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [ROWS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/cbba_word_unit.sv -----
// ----------------------------------------------------------------------------
// cbba_word_unit
// Shared word datapath: first-fit run search over one bitmap word, and the
// set/clear merge of a block range into one word.
// ----------------------------------------------------------------------------
module cbba_word_unit
  import cbba_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  input  scan_req_t            scan_req,
  output scan_res_t            scan_res,
  input  mark_req_t            mark_req,
  output logic [WORD_BITS-1:0] mark_word
);

  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] hit;
  logic [POS_W-1:0]     len [WORD_BITS];
  logic [OFF_W-1:0]     sel;
  logic [POS_W-1:0]     base;

  // run search: free run length ending at each bit, first bit that closes a run
  always_comb begin
    base = {scan_req.row, {OFF_W{1'b0}}};
    // blocks past the disk end count as taken
    for (int i = 0; i < WORD_BITS; i++) begin
      avail[i] = !word[i] &&
                 (scan_req.row != scan_req.lim_row || OFF_W'(i) <= scan_req.lim_off);
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      len[i] = scan_req.run_len + POS_W'(i + 1);
      for (int j = 0; j < WORD_BITS; j++) begin
        if (j < i && !avail[j]) begin
          len[i] = POS_W'(i - j);
        end
      end
      if (!avail[i]) begin
        len[i] = '0;
      end
      hit[i] = avail[i] && (len[i] >= scan_req.count);
    end
    // lowest hit wins
    sel = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel = OFF_W'(i);
      end
    end
    scan_res.found   = |hit;
    scan_res.first   = base + POS_W'(sel) + POS_W'(1) - len[sel];
    scan_res.run_len = len[WORD_BITS-1];
  end

  // range merge: bits inside [lo, hi] take the set value
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      if ((mark_req.row != mark_req.lo_row || OFF_W'(i) >= mark_req.lo_off) &&
          (mark_req.row != mark_req.hi_row || OFF_W'(i) <= mark_req.hi_off)) begin
        mark_word[i] = mark_req.set;
      end else begin
        mark_word[i] = word[i];
      end
    end
  end

endmodule
